### src/mesh_sink_dedup_ack_core_defines.svh
// ----------------------------------------------------------------------------
// mesh sink dedup/ack core: assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MESH_SINK_DEDUP_ACK_CORE_DEFINES_SVH
`define MESH_SINK_DEDUP_ACK_CORE_DEFINES_SVH

// same-cycle implication
`define MSDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/msda_pkg.sv
// ----------------------------------------------------------------------------
// msda_pkg
// types, codes and reset constants for the mesh sink dedup/ack core
// ----------------------------------------------------------------------------
package msda_pkg;

  // default cache depth
  localparam int CACHE_ENTRIES_DEF = 64;

  // field widths
  localparam int ORIGIN_W = 9;
  localparam int KEY_SEQ_W = 17;
  localparam int STAMP_W = 32;
  localparam int ACK_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 48;
  localparam int IN_TUSER_W = 3;
  localparam int OUT_TDATA_W = 64;

  // key codes for missing fields
  localparam logic [ORIGIN_W-1:0] ORIGIN_UNKNOWN = 9'h1FF;
  localparam logic [KEY_SEQ_W-1:0] SEQ_UNKNOWN = 17'h1FFFF;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd30000;
  localparam logic [15:0] INTERVAL_RST = 16'd10000;
  localparam logic [3:0] MAX_TTL_RST = 4'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_MAX_TTL = 2'd2;

  // input selector and packet kinds
  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_FLOOD = 2'd1;
  localparam logic [1:0] KIND_BEACON = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // input tdata layout, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        has_payload;
    logic [3:0]  ttl_value;
    logic        ttl_present;
    logic [15:0] seq_num;
    logic        seq_present;
    logic [7:0]  orig_node;
    logic        orig_present;
    logic [7:0]  src_node;
    logic        src_present;
  } in_data_t;

  // result tdata layout
  typedef struct packed {
    logic [5:0]          pad;
    logic [3:0]          hop_count;
    logic [ORIGIN_W-1:0] log_origin;
    logic                log_valid;
    logic [15:0]         acked_seq;
    logic [ACK_W-1:0]    ack_number;
    logic [7:0]          ack_dest;
    logic                send_ack;
    logic                cache_full;
    logic                is_new;
    logic                is_duplicate;
  } out_data_t;

  // one cache entry as stored in the ram
  typedef struct packed {
    logic                 valid;
    logic [ORIGIN_W-1:0]  origin;
    logic [KEY_SEQ_W-1:0] seq;
    logic [STAMP_W-1:0]   stamp;
  } entry_t;

  // status from the entry evaluation unit
  typedef struct packed {
    logic hit;
    logic free;
    logic expired;
  } eval_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_TICK  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_PRUNE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

### src/msda_ram.sv
// ----------------------------------------------------------------------------
// msda_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module msda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/msda_entry_eval.sv
// ----------------------------------------------------------------------------
// msda_entry_eval
// shared entry unit: key compare, free check and age compare of one entry
// ----------------------------------------------------------------------------
module msda_entry_eval (
  input  msda_pkg::entry_t                      entry,
  input  logic [msda_pkg::ORIGIN_W-1:0]         key_origin,
  input  logic [msda_pkg::KEY_SEQ_W-1:0]        key_seq,
  input  logic [msda_pkg::STAMP_W-1:0]          time_now,
  input  logic [15:0]                           timeout,
  output msda_pkg::eval_t                       status
);
  import msda_pkg::*;

  logic [STAMP_W-1:0] age;

  // age modulo 2^32
  assign age = time_now - entry.stamp;

  // key match, free slot and expiry
  assign status.hit = entry.valid && (entry.origin == key_origin) && (entry.seq == key_seq);
  assign status.free = !entry.valid;
  assign status.expired = entry.valid && (age > {16'b0, timeout});

endmodule

### src/mesh_sink_dedup_ack_core.sv
// ----------------------------------------------------------------------------
// mesh_sink_dedup_ack_core
// duplicate suppression cache with aging and ack numbering for a mesh sink
//
// channel  dir  handshake           payload
// in_      in   in_tvalid/tready    tuser: func, packet_kind; tdata: header fields
// out_     out  out_tvalid/tready   tdata: dedup flags, ack and log fields
// cfg_     in   cfg_we              cfg_index, cfg_data
//
// data or flood packet: one ram read per entry
// tick: advances time; a pruning pass runs when the prune interval is due
// beacon and other kinds: no transaction on the result side
// after reset a clearing pass over all entries runs before in_tready
// a result waits in the output register; a stalled output holds the next result
// ----------------------------------------------------------------------------
module mesh_sink_dedup_ack_core #(
  parameter int CACHE_ENTRIES = msda_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // from bit 0: src_present, src_node, orig_present, orig_node, seq_present,
  // seq_num, ttl_present, ttl_value, has_payload, zero pad
  input  logic [msda_pkg::IN_TDATA_W-1:0]     in_tdata,
  // from bit 0: func, packet_kind
  input  logic [msda_pkg::IN_TUSER_W-1:0]     in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // from bit 0: is_duplicate, is_new, cache_full, send_ack, ack_dest,
  // ack_number, acked_seq, log_valid, log_origin, hop_count, zero pad
  output logic [msda_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration
  input  logic                                cfg_we,
  input  logic [msda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msda_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import msda_pkg::*;

`include "mesh_sink_dedup_ack_core_defines.svh"

  localparam int AW = $clog2(CACHE_ENTRIES);
  localparam int CW = $clog2(CACHE_ENTRIES + 1);

  // configuration registers
  logic [15:0] timeout_r;
  logic [15:0] interval_r;
  logic [3:0]  max_ttl_r;

  // time and ack state
  logic [STAMP_W-1:0] time_now_r;
  logic [STAMP_W-1:0] last_prune_r;
  logic [ACK_W-1:0]   ack_cnt_r;
  logic [ACK_W-1:0]   ack_nxt;

  // sequencer
  state_t         state_r;
  state_t         state_nxt;
  logic [CW-1:0]  issue_idx_r;
  logic           issue_done;
  logic           rdv_r;
  logic [AW-1:0]  rd_idx_r;
  logic           dup_r;
  logic           slot_found_r;
  logic [AW-1:0]  slot_r;

  // captured packet
  logic [ORIGIN_W-1:0]  key_origin_r;
  logic [KEY_SEQ_W-1:0] key_seq_r;
  logic                 flood_r;
  logic                 src_p_r;
  logic [7:0]           src_r;
  logic                 orig_p_r;
  logic [7:0]           orig_r;
  logic                 seq_p_r;
  logic [15:0]          seq_r;
  logic                 ttl_p_r;
  logic [3:0]           ttl_r;
  logic                 payload_r;

  // input decode
  in_data_t             in_d;
  logic                 in_fire;
  logic                 pkt_keyed;
  logic [ORIGIN_W-1:0]  key_origin_in;
  logic [KEY_SEQ_W-1:0] key_seq_in;

  // ram and evaluation
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  entry_t        ram_rdata;
  eval_t         ev;
  logic          age_due;

  // result
  logic          out_free;
  logic          done_fire;
  logic          do_ack;
  logic          do_log;
  logic          do_insert;
  logic [3:0]    hops;
  out_data_t     res;
  logic          out_tvalid_r;
  out_data_t     out_data_r;

  assign in_d = in_data_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign pkt_keyed = (in_tuser[0] == FUNC_PACKET)
                     && ((in_tuser[2:1] == KIND_DATA) || (in_tuser[2:1] == KIND_FLOOD));

  // lookup key, missing fields map to codes that only match each other
  assign key_origin_in = in_d.orig_present ? {1'b0, in_d.orig_node}
                       : (in_d.src_present ? {1'b0, in_d.src_node} : ORIGIN_UNKNOWN);
  assign key_seq_in = in_d.seq_present ? {1'b0, in_d.seq_num} : SEQ_UNKNOWN;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      interval_r <= INTERVAL_RST;
      max_ttl_r <= MAX_TTL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEDUP_TIMEOUT:  timeout_r <= cfg_data;
        CFG_PRUNE_INTERVAL: interval_r <= cfg_data;
        CFG_FLOOD_MAX_TTL:  max_ttl_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // cache ram
  msda_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // shared entry unit
  msda_entry_eval u_eval (
    .entry      (ram_rdata),
    .key_origin (key_origin_r),
    .key_seq    (key_seq_r),
    .time_now   (time_now_r),
    .timeout    (timeout_r),
    .status     (ev)
  );

  assign issue_done = (issue_idx_r == CW'(CACHE_ENTRIES));
  assign ram_re = ((state_r == ST_SCAN) || (state_r == ST_PRUNE)) && !issue_done;
  assign age_due = ((time_now_r - last_prune_r) >= {16'b0, interval_r});

  // result assembly
  assign out_free = !out_tvalid_r || out_tready;
  assign done_fire = (state_r == ST_DONE) && out_free;
  assign do_ack = src_p_r && seq_p_r;
  assign do_log = !dup_r && payload_r;
  assign do_insert = !dup_r && slot_found_r;
  assign ack_nxt = ack_cnt_r + 16'd1;

  // hop count per packet kind
  always_comb begin
    if (flood_r) begin
      hops = (ttl_p_r && (max_ttl_r > ttl_r)) ? (max_ttl_r - ttl_r) : 4'd0;
    end else begin
      hops = (orig_p_r && (!src_p_r || (orig_r != src_r))) ? 4'd2 : 4'd1;
    end
  end

  always_comb begin
    res = '0;
    res.is_duplicate = dup_r;
    res.is_new = !dup_r;
    res.cache_full = !dup_r && !slot_found_r;
    res.send_ack = do_ack;
    res.ack_dest = do_ack ? src_r : 8'd0;
    res.ack_number = do_ack ? ack_nxt : '0;
    res.acked_seq = do_ack ? seq_r : 16'd0;
    res.log_valid = do_log;
    res.log_origin = do_log ? key_origin_r : '0;
    res.hop_count = do_log ? hops : 4'd0;
  end

  // ram write select: clearing pass, prune, insert
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = !issue_done;
        ram_waddr = issue_idx_r[AW-1:0];
      end
      ST_PRUNE: begin
        ram_we = rdv_r && ev.expired;
        ram_waddr = rd_idx_r;
        ram_wdata = ram_rdata;
        ram_wdata.valid = 1'b0;
      end
      ST_DONE: begin
        ram_we = done_fire && do_insert;
        ram_wdata.valid = 1'b1;
        ram_wdata.origin = key_origin_r;
        ram_wdata.seq = key_seq_r;
        ram_wdata.stamp = time_now_r;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (issue_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire && (in_tuser[0] == FUNC_TICK)) begin
          state_nxt = ST_TICK;
        end else if (in_fire && pkt_keyed) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_TICK:  state_nxt = age_due ? ST_PRUNE : ST_IDLE;
      ST_SCAN:  if (issue_done && !rdv_r) state_nxt = ST_DONE;
      ST_PRUNE: if (issue_done && !rdv_r) state_nxt = ST_IDLE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      issue_idx_r <= '0;
      rdv_r <= 1'b0;
      dup_r <= 1'b0;
      slot_found_r <= 1'b0;
      time_now_r <= '0;
      last_prune_r <= '0;
      ack_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      rdv_r <= ram_re;
      // walk counter: clearing pass, scan and prune issue
      if ((state_r == ST_CLEAR) && !issue_done) begin
        issue_idx_r <= issue_idx_r + CW'(1);
      end else if (ram_re) begin
        issue_idx_r <= issue_idx_r + CW'(1);
      end else if ((state_r == ST_IDLE) || (state_r == ST_TICK)) begin
        issue_idx_r <= '0;
      end
      // tick advances time
      if (in_fire && (in_tuser[0] == FUNC_TICK)) begin
        time_now_r <= time_now_r + 32'd1;
      end
      if ((state_r == ST_TICK) && age_due) begin
        last_prune_r <= time_now_r;
      end
      // lookup results
      if (in_fire) begin
        dup_r <= 1'b0;
        slot_found_r <= 1'b0;
      end else if ((state_r == ST_SCAN) && rdv_r) begin
        if (ev.hit) begin
          dup_r <= 1'b1;
        end
        if (ev.free && !slot_found_r) begin
          slot_found_r <= 1'b1;
        end
      end
      if (done_fire && do_ack) begin
        ack_cnt_r <= ack_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx_r <= issue_idx_r[AW-1:0];
    end
    if ((state_r == ST_SCAN) && rdv_r && ev.free && !slot_found_r) begin
      slot_r <= rd_idx_r;
    end
    if (in_fire) begin
      key_origin_r <= key_origin_in;
      key_seq_r <= key_seq_in;
      flood_r <= (in_tuser[2:1] == KIND_FLOOD);
      src_p_r <= in_d.src_present;
      src_r <= in_d.src_node;
      orig_p_r <= in_d.orig_present;
      orig_r <= in_d.orig_node;
      seq_p_r <= in_d.seq_present;
      seq_r <= in_d.seq_num;
      ttl_p_r <= in_d.ttl_present;
      ttl_r <= in_d.ttl_value;
      payload_r <= in_d.has_payload;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = OUT_TDATA_W'(out_data_r);

  // checks
  `MSDA_ASSERT_NOW(a_ram_we_state,
    ram_we, (state_r == ST_CLEAR) || (state_r == ST_PRUNE) || (state_r == ST_DONE),
    "cache written outside clear, prune or insert")
  `MSDA_ASSERT_NOW(a_dup_xor_new,
    out_tvalid_r, out_data_r.is_duplicate != out_data_r.is_new,
    "result is both or neither duplicate and new")
  `MSDA_ASSERT_NOW(a_full_is_new,
    out_tvalid_r && out_data_r.cache_full, out_data_r.is_new && !out_data_r.is_duplicate,
    "cache full flagged on a duplicate")
  `MSDA_ASSERT_NEXT(a_ack_count,
    done_fire && do_ack, ack_cnt_r == ACK_W'($past(ack_cnt_r) + 16'd1),
    "ack counter did not advance on an acknowledged packet")

endmodule
